// File: sv/rmp_pkg.sv
// Package for the sound chip channel remapper.
// Holds item types, register codes, mode codes and configuration indexes.
// Used by the top level, its checker and the testbench.
package rmp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_TYPE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_CHANNEL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CHIP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_CYCLE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_INTERVAL = 3'd5;

	// Map modes.
	localparam logic [1:0] MODE_NONE      = 2'd0;
	localparam logic [1:0] MODE_MUTE      = 2'd1;
	localparam logic [1:0] MODE_MAP_CHIP0 = 2'd2;
	localparam logic [1:0] MODE_MAP_CHIP1 = 2'd3;

	// Map types.
	localparam logic [1:0] TYPE_TONE  = 2'd0;
	localparam logic [1:0] TYPE_NOISE = 2'd1;
	localparam logic [1:0] TYPE_ALL   = 2'd2;

	// Auto cycle modes.
	localparam logic [1:0] CYCLE_OFF        = 2'd0;
	localparam logic [1:0] CYCLE_TONE_ALL   = 2'd1;
	localparam logic [1:0] CYCLE_NOISE_ALL  = 2'd2;
	localparam logic [1:0] CYCLE_ROTATE     = 2'd3;

	// Opcodes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Sound chip register numbers.
	localparam logic [4:0] REG_AMP   = 5'h00;
	localparam logic [4:0] REG_FREQ  = 5'h08;
	localparam logic [4:0] REG_OCT   = 5'h10;
	localparam logic [4:0] REG_FEN   = 5'h14;
	localparam logic [4:0] REG_NEN   = 5'h15;
	localparam logic [4:0] REG_NCTL  = 5'h16;
	localparam logic [4:0] REG_SND   = 5'h1C;

	localparam logic [4:0] REG_MASK   = 5'h1F;
	localparam logic [7:0] MASK_OCT   = 8'hF0;
	localparam logic [7:0] MASK_NCTL  = 8'h07;
	localparam logic [7:0] MASK_BIT0  = 8'hFE;
	localparam logic [7:0] MASK_BIT01 = 8'hFC;

	localparam logic [2:0] LAST_LOW_CHANNEL = 3'd2;

	typedef struct packed {
		logic       opcode;
		logic       chip_slot;
		logic [7:0] reg_addr;
		logic [7:0] reg_data;
	} in_item_t;

	typedef struct packed {
		logic       write_slot;
		logic [4:0] write_reg;
		logic [7:0] write_data;
		logic       last_write;
	} out_item_t;

endpackage

// File: sv/rmp_stream_if.sv
// Valid/ready stream interface for the remapper channels.
// The payload type is a parameter; the item types come from rmp_pkg.
interface rmp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/sound_chip_channel_remapper.sv
// Channel remapper for a pair of six-channel sound chips.
// Depends on rmp_pkg and rmp_stream_if.
//
// The block accepts one item per cycle, when not stalled, into an input register, decodes
// it there and loads up to two bus writes into a two-entry result register. Ticks and
// writes that cause no bus write leave without waiting on the output; a write that causes
// one bus write leaves once the result register drains, so such items flow at one per
// cycle while the output is not stalled. A redirected write plus the original holds the
// result register until both leave by the single output port. The user must write
// configuration through the plain write port while the block is idle; it is not enforced.
module sound_chip_channel_remapper import rmp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rmp_stream_if.sink            in_ch,
	rmp_stream_if.source          out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [1:0]            map_mode_q;
	logic [2:0]            target_q;
	logic                  second_chip_q;
	logic [1:0]            auto_cycle_q;
	logic [CFG_DATA_W-1:0] interval_q;
	logic [1:0]            cur_type_q;
	logic [CFG_DATA_W-1:0] tick_q;

	logic      valid_s1;
	in_item_t  item_s1;

	logic [1:0] cnt_q;
	out_item_t  res0_q;
	out_item_t  res1_q;

	logic       is_tick;
	logic [4:0] reg5;
	logic [7:0] din;
	logic       ts;
	logic       tone;
	logic       noise;
	logic       mute;
	logic       remap;
	logic       extra_v;
	out_item_t  extra;
	logic       orig_v;
	out_item_t  orig;
	out_item_t  first;
	logic [1:0] nres;
	logic       out_fire;
	logic       out_room;
	logic       s1_go;
	logic       tick_en;
	logic [CFG_DATA_W-1:0] tick_inc;

	function automatic logic [1:0] next_type(input logic [1:0] mode, input logic [1:0] cur);
		logic [1:0] r;
		case (mode)
			CYCLE_TONE_ALL:  r = (cur == TYPE_TONE) ? TYPE_ALL : TYPE_TONE;
			CYCLE_NOISE_ALL: r = (cur == TYPE_NOISE) ? TYPE_ALL : TYPE_NOISE;
			default:         r = (cur >= TYPE_ALL) ? TYPE_TONE : cur + 2'd1;
		endcase
		return r;
	endfunction

	assign is_tick = (item_s1.opcode == OP_TICK);
	assign reg5    = item_s1.reg_addr[4:0] & REG_MASK;
	assign din     = item_s1.reg_data;
	assign ts      = (map_mode_q == MODE_MAP_CHIP1);
	assign tone    = (cur_type_q == TYPE_TONE) || (cur_type_q == TYPE_ALL);
	assign noise   = (cur_type_q == TYPE_NOISE) || (cur_type_q == TYPE_ALL);

	always_comb begin
		mute  = 1'b0;
		remap = 1'b0;
		if (!item_s1.chip_slot && map_mode_q != MODE_NONE) begin
			if (map_mode_q == MODE_MUTE) begin
				mute = 1'b1;
			end else if (ts && !second_chip_q) begin
				mute = 1'b1;
			end else if (ts || target_q != 3'd0) begin
				remap = 1'b1;
			end
		end
	end

	always_comb begin
		extra_v = 1'b0;
		extra   = '{write_slot: ts, write_reg: reg5, write_data: din, last_write: 1'b0};
		orig_v  = 1'b1;
		orig    = '{write_slot: item_s1.chip_slot, write_reg: reg5, write_data: din,
			last_write: 1'b1};
		if (mute) begin
			case (reg5)
				REG_AMP, REG_FREQ: orig_v = 1'b0;
				REG_OCT:           orig.write_data = din & MASK_OCT;
				REG_FEN, REG_NEN:  orig.write_data = din & MASK_BIT0;
				REG_NCTL:          orig.write_data = din & MASK_BIT01;
				default:           orig_v = 1'b1;
			endcase
		end else if (remap) begin
			case (reg5)
				REG_AMP, REG_FREQ: begin
					if (tone) begin
						extra_v          = 1'b1;
						extra.write_reg  = reg5 + {2'b00, target_q};
						extra.last_write = 1'b1;
						orig_v           = 1'b0;
					end
				end
				REG_OCT: begin
					if (tone) begin
						extra_v          = 1'b1;
						extra.write_reg  = REG_OCT + {3'b000, target_q[2:1]};
						extra.write_data = target_q[0] ? {din[3:0], 4'h0} : {4'h0, din[3:0]};
						orig.write_data  = din & MASK_OCT;
					end
				end
				REG_FEN, REG_NEN: begin
					if ((reg5 == REG_FEN && tone) || (reg5 == REG_NEN && noise)) begin
						extra_v          = din[0];
						extra.write_data = 8'd1 << target_q;
						orig.write_data  = din & MASK_BIT0;
					end
				end
				REG_NCTL: begin
					if (noise) begin
						extra_v          = 1'b1;
						extra.write_data = (target_q <= LAST_LOW_CHANNEL) ?
							(din & MASK_NCTL) : {(din[3:0] & MASK_NCTL[3:0]), 4'h0};
						orig.write_data  = din & ~MASK_NCTL;
					end
				end
				REG_SND: begin
					if (ts) begin
						extra_v          = 1'b1;
						extra.write_slot = 1'b1;
					end
				end
				default: extra_v = 1'b0;
			endcase
		end
	end

	assign first    = extra_v ? extra : orig;
	assign nres     = is_tick ? 2'd0 : ({1'b0, extra_v} + {1'b0, orig_v});
	assign out_fire = out_ch.valid && out_ch.ready;
	assign out_room = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_fire);
	assign s1_go    = valid_s1 && (nres == 2'd0 || out_room);
	assign tick_en  = s1_go && is_tick && auto_cycle_q != CYCLE_OFF && interval_q != '0;
	assign tick_inc = tick_q + 1'b1;

	assign in_ch.ready    = !valid_s1 || s1_go;
	assign out_ch.valid   = (cnt_q != 2'd0);
	assign out_ch.payload = res0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q    <= MODE_NONE;
			target_q      <= 3'd0;
			second_chip_q <= 1'b0;
			auto_cycle_q  <= CYCLE_OFF;
			interval_q    <= '0;
			cur_type_q    <= TYPE_ALL;
			tick_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MAP_MODE: map_mode_q <= cfg_wdata[1:0];
				CFG_MAP_TYPE: begin
					if (cfg_wdata[1:0] <= TYPE_ALL) begin
						cur_type_q <= cfg_wdata[1:0];
					end
				end
				CFG_TARGET_CHANNEL: begin
					if (cfg_wdata[2:0] <= 3'd5) begin
						target_q <= cfg_wdata[2:0];
					end
				end
				CFG_SECOND_CHIP: second_chip_q <= cfg_wdata[0];
				CFG_AUTO_CYCLE: begin
					auto_cycle_q <= cfg_wdata[1:0];
					tick_q       <= '0;
					if (cfg_wdata[1:0] == CYCLE_TONE_ALL || cfg_wdata[1:0] == CYCLE_ROTATE) begin
						cur_type_q <= TYPE_TONE;
					end else if (cfg_wdata[1:0] == CYCLE_NOISE_ALL) begin
						cur_type_q <= TYPE_NOISE;
					end
				end
				CFG_CYCLE_INTERVAL: interval_q <= cfg_wdata;
				default: interval_q <= interval_q;
			endcase
		end else if (tick_en) begin
			if (tick_inc >= interval_q) begin
				tick_q     <= '0;
				cur_type_q <= next_type(auto_cycle_q, cur_type_q);
			end else begin
				tick_q <= tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (s1_go && nres != 2'd0) begin
				cnt_q <= nres;
			end else if (out_fire) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
		if (s1_go && nres != 2'd0) begin
			res0_q <= first;
			res1_q <= orig;
		end else if (out_fire) begin
			res0_q <= res1_q;
		end
	end

endmodule

// File: sv/rmp_checker.sv
// Port-level checker for the sound chip channel remapper, bound to the top level.
// Depends on rmp_pkg for the result item type.
module rmp_checker import rmp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A stalled result stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// Nothing is offered while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// The second write of a pair is already buffered when the first is taken.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_write |=> out_valid)
		else $error("second write of a pair missing");

	// An item causes at most two writes, so a non-final write is followed by the final one.
	a_pair_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_write |=> out_item.last_write)
		else $error("more than two writes for one item");

endmodule

bind sound_chip_channel_remapper rmp_checker u_rmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.payload)
);

// File: verif/sound_chip_channel_remapper_tb.sv
// Testbench for the sound chip channel remapper: random and directed register writes and
// wait ticks go in over a stream, and every bus write that comes out is checked in order.
// Depends on rmp_pkg, rmp_stream_if and sound_chip_channel_remapper.
`timescale 1ns / 1ps

module sound_chip_channel_remapper_tb;
	import rmp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int NUM_PHASES     = 12;
	localparam int PHASE_ITEMS    = 50;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rmp_stream_if #(.T(in_item_t))  in_if ();
	rmp_stream_if #(.T(out_item_t)) out_if ();

	sound_chip_channel_remapper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if.sink),
		.out_ch    (out_if.source),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	in_item_t  pending_items [$];
	out_item_t expected_writes [$];

	logic [1:0]  mdl_mode;
	logic [2:0]  mdl_target;
	logic        mdl_second_chip;
	logic [1:0]  mdl_cycle_mode;
	logic [13:0] mdl_interval;
	logic [1:0]  mdl_map_type;
	logic [13:0] mdl_ticks;

	int err_count;
	int idle_cycles;
	int burst_left;
	int gap_left;
	int stall_pct;
	int cycle_count;
	bit in_taken;
	logic [CFG_IDX_W-1:0] cfg_codes [6];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void push_write(logic slot, logic [4:0] r, logic [7:0] d, logic last);
		out_item_t w;
		w.write_slot = slot;
		w.write_reg  = r;
		w.write_data = d;
		w.last_write = last;
		expected_writes.push_back(w);
	endfunction

	function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_MAP_MODE: mdl_mode = v[1:0];
			CFG_MAP_TYPE: begin
				if (v[1:0] <= TYPE_ALL) begin
					mdl_map_type = v[1:0];
				end
			end
			CFG_TARGET_CHANNEL: begin
				if (v[2:0] <= 3'd5) begin
					mdl_target = v[2:0];
				end
			end
			CFG_SECOND_CHIP: mdl_second_chip = v[0];
			CFG_AUTO_CYCLE: begin
				mdl_cycle_mode = v[1:0];
				mdl_ticks = '0;
				if (mdl_cycle_mode == CYCLE_TONE_ALL || mdl_cycle_mode == CYCLE_ROTATE) begin
					mdl_map_type = TYPE_TONE;
				end else if (mdl_cycle_mode == CYCLE_NOISE_ALL) begin
					mdl_map_type = TYPE_NOISE;
				end
			end
			CFG_CYCLE_INTERVAL: mdl_interval = v;
			default: ;
		endcase
	endfunction

	function automatic void advance_cycle_timer();
		if (mdl_cycle_mode == CYCLE_OFF || mdl_interval == '0) begin
			return;
		end
		mdl_ticks = mdl_ticks + 14'd1;
		if (mdl_ticks < mdl_interval) begin
			return;
		end
		mdl_ticks = '0;
		case (mdl_cycle_mode)
			CYCLE_TONE_ALL:
				mdl_map_type = (mdl_map_type == TYPE_TONE) ? TYPE_ALL : TYPE_TONE;
			CYCLE_NOISE_ALL:
				mdl_map_type = (mdl_map_type == TYPE_NOISE) ? TYPE_ALL : TYPE_NOISE;
			default:
				mdl_map_type = (mdl_map_type >= TYPE_ALL) ? TYPE_TONE : mdl_map_type + 2'd1;
		endcase
	endfunction

	function automatic void predict_bus_writes(in_item_t it);
		logic [4:0] r;
		logic [7:0] d;
		logic [7:0] side;
		logic       mute;
		logic       remap;
		logic       ts;
		logic       tone;
		logic       noise;
		r = it.reg_addr[4:0] & REG_MASK;
		d = it.reg_data;
		mute = 1'b0;
		remap = 1'b0;
		ts = (mdl_mode == MODE_MAP_CHIP1);
		if (it.opcode == OP_TICK) begin
			advance_cycle_timer();
			return;
		end
		if (!it.chip_slot && mdl_mode != MODE_NONE) begin
			if (mdl_mode == MODE_MUTE) begin
				mute = 1'b1;
			end else if (ts && !mdl_second_chip) begin
				mute = 1'b1;
			end else if (ts || mdl_target != 3'd0) begin
				remap = 1'b1;
			end
		end
		if (mute) begin
			if (r == REG_AMP || r == REG_FREQ) begin
				return;
			end
			if (r == REG_OCT) d = d & MASK_OCT;
			if (r == REG_FEN || r == REG_NEN) d = d & MASK_BIT0;
			if (r == REG_NCTL) d = d & MASK_BIT01;
		end else if (remap) begin
			tone  = (mdl_map_type == TYPE_TONE || mdl_map_type == TYPE_ALL);
			noise = (mdl_map_type == TYPE_NOISE || mdl_map_type == TYPE_ALL);
			if ((r == REG_AMP || r == REG_FREQ) && tone) begin
				push_write(ts, r + 5'(mdl_target), d, 1'b1);
				return;
			end
			if (r == REG_OCT && tone) begin
				side = d & ~MASK_OCT;
				side = mdl_target[0] ? (side << 4) : side;
				push_write(ts, REG_OCT + 5'(mdl_target >> 1), side, 1'b0);
				d = d & MASK_OCT;
			end
			if ((r == REG_FEN && tone) || (r == REG_NEN && noise)) begin
				if (d[0]) begin
					side = 8'd1 << mdl_target;
					push_write(ts, r, side, 1'b0);
				end
				d = d & MASK_BIT0;
			end
			if (r == REG_NCTL && noise) begin
				side = d & MASK_NCTL;
				side = (mdl_target <= LAST_LOW_CHANNEL) ? side : (side << 4);
				push_write(ts, REG_NCTL, side, 1'b0);
				d = d & ~MASK_NCTL;
			end
			if (r == REG_SND && ts) begin
				push_write(1'b1, REG_SND, d, 1'b0);
			end
		end
		push_write(it.chip_slot, r, d, 1'b1);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic [4:0] r;
		case ($urandom_range(0, 9))
			0:       r = REG_AMP + 5'($urandom_range(0, 7));
			1:       r = REG_FREQ + 5'($urandom_range(0, 7));
			2:       r = REG_OCT + 5'($urandom_range(0, 3));
			3:       r = REG_FEN;
			4:       r = REG_NEN;
			5:       r = REG_NCTL;
			6:       r = REG_SND;
			7:       r = REG_FREQ;
			default: r = 5'($urandom_range(0, 31));
		endcase
		it.opcode    = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_WRITE;
		it.chip_slot = ($urandom_range(0, 3) == 0);
		it.reg_addr  = {3'($urandom_range(0, 7)), r};
		case ($urandom_range(0, 7))
			0:       it.reg_data = 8'h00;
			1:       it.reg_data = 8'hFF;
			default: it.reg_data = 8'($urandom_range(0, 255));
		endcase
		return it;
	endfunction

	function automatic void add_item(logic op, logic slot, logic [7:0] addr, logic [7:0] data);
		in_item_t it;
		it.opcode    = op;
		it.chip_slot = slot;
		it.reg_addr  = addr;
		it.reg_data  = data;
		pending_items.push_back(it);
	endfunction

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (pending_items.size() != 0 || in_if.valid || expected_writes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure_phase(int phase);
		logic [CFG_DATA_W-1:0] vals [6];
		int order [6];
		int j;
		int tmp;
		for (int i = 0; i < 6; i++) begin
			order[i] = i;
			vals[i] = 14'($urandom_range(0, 16383));
		end
		case ($urandom_range(0, 5))
			0:       vals[5] = '0;
			1:       vals[5] = 14'd1;
			2:       vals[5] = 14'd2;
			3:       vals[5] = 14'($urandom_range(3, 8));
			4:       vals[5] = 14'd10000;
			default: vals[5] = 14'($urandom_range(0, 16383));
		endcase
		if (phase == 0 || phase == 2) begin
			vals[0] = 14'(MODE_MAP_CHIP1);
			vals[1] = 14'(TYPE_ALL);
			vals[2] = 14'd5;
			vals[3] = 14'd1;
			vals[4] = 14'(CYCLE_ROTATE);
			vals[5] = (phase == 0) ? 14'h3FFF : 14'd1;
		end else if (phase == 1) begin
			for (int i = 0; i < 6; i++) vals[i] = '0;
		end
		for (int i = 5; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 6; i++) begin
			write_cfg(cfg_codes[order[i]], vals[order[i]]);
		end
	endtask

	// Driver: items go out in bursts with gaps; ready follows a stall rate that changes often.
	always @(negedge clk) begin : driver
		logic     nv;
		in_item_t np;
		nv = (in_if.valid === 1'b1);
		np = in_if.payload;
		if (in_taken) begin
			nv = 1'b0;
			in_taken = 1'b0;
		end
		if (!nv && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				np = pending_items.pop_front();
				nv = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_if.valid   <= nv;
		in_if.payload <= np;
		cycle_count++;
		if (cycle_count % 64 == 0) begin
			case ($urandom_range(0, 2))
				0:       stall_pct = 0;
				1:       stall_pct = 25;
				default: stall_pct = 60;
			endcase
		end
		out_if.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin : monitor
		out_item_t e;
		if (arst_n) begin
			if (cfg_we) begin
				apply_config(cfg_idx, cfg_wdata);
			end
			if (in_if.valid && in_if.ready) begin
				predict_bus_writes(in_if.payload);
				in_taken = 1'b1;
			end
			if (out_if.valid && out_if.ready) begin
				if (expected_writes.size() == 0) begin
					err_count++;
					$display("%0t: unexpected write, expected none, %s slot=%0d reg=%h data=%h last=%0d",
						$time, "actual", out_if.payload.write_slot, out_if.payload.write_reg,
						out_if.payload.write_data, out_if.payload.last_write);
				end else begin
					e = expected_writes.pop_front();
					if (out_if.payload.write_slot !== e.write_slot ||
							out_if.payload.write_reg !== e.write_reg ||
							out_if.payload.write_data !== e.write_data ||
							out_if.payload.last_write !== e.last_write) begin
						err_count++;
						$display("%0t: mismatch, expected slot=%0d reg=%h data=%h last=%0d,",
							$time, e.write_slot, e.write_reg, e.write_data, e.last_write,
							" actual slot=%0d reg=%h data=%h last=%0d",
							out_if.payload.write_slot, out_if.payload.write_reg,
							out_if.payload.write_data, out_if.payload.last_write);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || cfg_we || (in_if.valid && in_if.ready) ||
				(out_if.valid && out_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b1;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_if.valid = 1'b0;
		in_if.payload = '0;
		out_if.ready = 1'b0;
		err_count = 0;
		idle_cycles = 0;
		burst_left = 1;
		gap_left = 0;
		stall_pct = 0;
		cycle_count = 0;
		in_taken = 1'b0;
		cfg_codes[0] = CFG_MAP_MODE;
		cfg_codes[1] = CFG_MAP_TYPE;
		cfg_codes[2] = CFG_TARGET_CHANNEL;
		cfg_codes[3] = CFG_SECOND_CHIP;
		cfg_codes[4] = CFG_AUTO_CYCLE;
		cfg_codes[5] = CFG_CYCLE_INTERVAL;
		mdl_mode = MODE_NONE;
		mdl_map_type = TYPE_ALL;
		mdl_target = '0;
		mdl_second_chip = 1'b0;
		mdl_cycle_mode = CYCLE_OFF;
		mdl_interval = '0;
		mdl_ticks = '0;
		#1;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings pass everything through.
		add_item(OP_WRITE, 1'b0, 8'h00, 8'h00);
		add_item(OP_WRITE, 1'b1, 8'hFF, 8'hFF);
		add_item(OP_TICK, 1'b1, 8'hFF, 8'hFF);
		wait_idle();

		write_cfg(CFG_MAP_MODE, 14'(MODE_MUTE));
		write_cfg(CFG_SPARE_LO, 14'h3FFF);
		write_cfg(CFG_SPARE_HI, 14'h3FFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_AMP}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b111, REG_FREQ}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_OCT}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_FEN}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_NEN}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_NCTL}, 8'hFF);
		wait_idle();

		// Map to the second chip, last channel, all types, with a map type and a channel
		// that are out of range and must be ignored.
		write_cfg(CFG_MAP_MODE, 14'(MODE_MAP_CHIP1));
		write_cfg(CFG_SECOND_CHIP, 14'd1);
		write_cfg(CFG_TARGET_CHANNEL, 14'd5);
		write_cfg(CFG_TARGET_CHANNEL, 14'd7);
		write_cfg(CFG_MAP_TYPE, 14'(TYPE_ALL));
		write_cfg(CFG_MAP_TYPE, 14'd3);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_AMP}, 8'h5A);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_FREQ}, 8'hA5);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_OCT}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_FEN}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_FEN}, 8'h00);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_NCTL}, 8'hFF);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_SND}, 8'hAB);
		add_item(OP_WRITE, 1'b1, {3'b000, REG_AMP}, 8'h33);
		wait_idle();

		// Second chip missing acts as mute; chip 0 with channel zero passes through.
		write_cfg(CFG_SECOND_CHIP, 14'd0);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_AMP}, 8'h11);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_NCTL}, 8'hFF);
		wait_idle();
		write_cfg(CFG_MAP_MODE, 14'(MODE_MAP_CHIP0));
		write_cfg(CFG_TARGET_CHANNEL, 14'd0);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_AMP}, 8'h22);
		add_item(OP_WRITE, 1'b0, {3'b000, REG_OCT}, 8'hFF);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			configure_phase(p);
			for (int i = 0; i < PHASE_ITEMS / 2; i++) pending_items.push_back(random_item());
			wait_idle();
			for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) begin
				pending_items.push_back(random_item());
			end
			wait_idle();
		end

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
